// ===== hdl/dllc_pkg.sv =====
`default_nettype none
package dllc_pkg;

  // Field widths fixed by the transaction format
  localparam int FUNC_W = 4;
  localparam int DATA_W = 32;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_INS_HEAD   = 4'd0;
  localparam logic [FUNC_W-1:0] OP_INS_TAIL   = 4'd1;
  localparam logic [FUNC_W-1:0] OP_POP_HEAD   = 4'd2;
  localparam logic [FUNC_W-1:0] OP_POP_TAIL   = 4'd3;
  localparam logic [FUNC_W-1:0] OP_PEEK_HEAD  = 4'd4;
  localparam logic [FUNC_W-1:0] OP_PEEK_TAIL  = 4'd5;
  localparam logic [FUNC_W-1:0] OP_CUR_HEAD   = 4'd6;
  localparam logic [FUNC_W-1:0] OP_CUR_TAIL   = 4'd7;
  localparam logic [FUNC_W-1:0] OP_CUR_FWD    = 4'd8;
  localparam logic [FUNC_W-1:0] OP_CUR_BACK   = 4'd9;
  localparam logic [FUNC_W-1:0] OP_PEEK_CUR   = 4'd10;
  localparam logic [FUNC_W-1:0] OP_INS_AFTER  = 4'd11;
  localparam logic [FUNC_W-1:0] OP_INS_BEFORE = 4'd12;
  localparam logic [FUNC_W-1:0] OP_DEL_CUR    = 4'd13;
  localparam logic [FUNC_W-1:0] OP_STATUS     = 4'd14;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [DATA_W-1:0] data_t;

endpackage
`default_nettype wire

// ===== hdl/dllc_if.sv =====
`default_nettype none
// Command channel
interface dllc_cmd_if;
  logic                 valid;
  logic                 ready;
  dllc_pkg::func_t      func;
  dllc_pkg::data_t      value_in;

  modport source (output valid, output func, output value_in, input ready);
  modport sink   (input valid, input func, input value_in, output ready);
endinterface

// Result channel
interface dllc_res_if #(
  parameter int COUNT_W = 7
);
  logic                 valid;
  logic                 ready;
  dllc_pkg::data_t      value_out;
  logic                 ok;
  logic [COUNT_W-1:0]   count;
  logic                 is_empty;
  logic                 at_first;
  logic                 at_last;

  modport source (output valid, output value_out, output ok, output count,
                  output is_empty, output at_first, output at_last, input ready);
  modport sink   (input valid, input value_out, input ok, input count,
                  input is_empty, input at_first, input at_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/doubly_linked_list_with_cursor.sv =====
`default_nettype none
// Steps in order: accept (S_IDLE), registered link read (S_LD), node
// write (S_WA), neighbor write and pointer update (S_WB), where the
// result is registered; a removal writes its neighbors in S_WA. One
// command at a time: a new one is accepted only in S_IDLE, as the writes
// share the single write port of each link memory. A stalled result holds
// the sequencer in its last step. rst (synchronous) empties the list; no
// memory sweep is needed since never-used nodes come from a fill counter.
module doubly_linked_list_with_cursor #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  dllc_cmd_if.sink   cmd,
  dllc_res_if.source res
);

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = IW + 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (VALUE_WIDTH < dllc_pkg::DATA_W) ? VALUE_WIDTH : dllc_pkg::DATA_W;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LD   = 2'd1;
  localparam logic [1:0] S_WA   = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  logic [1:0]      state;
  logic [LW-1:0]   head, tail, cur;
  logic [CW-1:0]   cnt, fs_sp, hw;
  dllc_pkg::func_t op;
  logic [SW-1:0]   vin;
  logic [LW-1:0]   tgt, tn, tp, node;
  logic [SW-1:0]   tv;
  logic            full;

  logic            ov, o_ok, o_empty, o_first, o_last;
  logic [31:0]     o_value;
  logic [CW-1:0]   o_cnt;

  logic [LW-1:0]   tgt_sel;
  logic [LW-1:0]   next_rd, prev_rd;
  logic [SW-1:0]   val_rd;
  logic [IW-1:0]   fs_rd;
  logic            empty;

  // Pick the node an operation reads from
  always_comb begin
    case (cmd.func)
      dllc_pkg::OP_POP_HEAD, dllc_pkg::OP_PEEK_HEAD, dllc_pkg::OP_CUR_HEAD: tgt_sel = head;
      dllc_pkg::OP_POP_TAIL, dllc_pkg::OP_PEEK_TAIL, dllc_pkg::OP_CUR_TAIL: tgt_sel = tail;
      default: tgt_sel = cur;
    endcase
  end

  assign empty = (cnt == '0);

  // Neighbors of the node being placed or removed
  logic [LW-1:0] p, q;
  logic          ins, rem, do_ins;
  always_comb begin
    p = NIL;
    q = NIL;
    ins = 1'b0;
    rem = 1'b0;
    case (op)
      dllc_pkg::OP_INS_HEAD: begin
        ins = 1'b1;
        q = head;
      end
      dllc_pkg::OP_INS_TAIL: begin
        ins = 1'b1;
        p = tail;
      end
      dllc_pkg::OP_INS_AFTER: begin
        ins = 1'b1;
        if (!empty) begin
          p = cur;
          q = tn;
        end
      end
      dllc_pkg::OP_INS_BEFORE: begin
        ins = 1'b1;
        if (!empty) begin
          p = tp;
          q = cur;
        end
      end
      dllc_pkg::OP_POP_HEAD, dllc_pkg::OP_POP_TAIL, dllc_pkg::OP_DEL_CUR: begin
        rem = !empty;
        p = tp;
        q = tn;
      end
      default: begin
        p = NIL;
      end
    endcase
  end
  assign do_ins = ins && !full;

  // Memory write ports
  logic          nx_we, pv_we, vl_we, fs_we;
  logic [LW-1:0] nx_wa, pv_wa, nx_wd, pv_wd;
  always_comb begin
    nx_we = 1'b0;
    pv_we = 1'b0;
    nx_wa = p;
    nx_wd = q;
    pv_wa = q;
    pv_wd = p;
    if (state == S_WA) begin
      if (do_ins) begin
        nx_we = 1'b1;
        nx_wa = node;
        pv_we = 1'b1;
        pv_wa = node;
      end else if (rem) begin
        nx_we = (p != NIL);
        pv_we = (q != NIL);
      end
    end else if (state == S_WB && do_ins) begin
      nx_we = (p != NIL);
      nx_wd = node;
      pv_we = (q != NIL);
      pv_wd = node;
    end
  end
  assign vl_we = (state == S_WA) && do_ins;
  assign fs_we = (state == S_WA) && rem;

  dllc_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa[IW-1:0]), .wdata(nx_wd),
    .raddr(tgt_sel[IW-1:0]), .rdata(next_rd)
  );
  dllc_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa[IW-1:0]), .wdata(pv_wd),
    .raddr(tgt_sel[IW-1:0]), .rdata(prev_rd)
  );
  dllc_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_value (
    .clk(clk), .we(vl_we), .waddr(node[IW-1:0]), .wdata(vin),
    .raddr(tgt_sel[IW-1:0]), .rdata(val_rd)
  );
  dllc_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free (
    .clk(clk), .we(fs_we), .waddr(fs_sp[IW-1:0]), .wdata(tgt[IW-1:0]),
    .raddr(IW'(fs_sp - 1'b1)), .rdata(fs_rd)
  );

  // Pointer update and result of the operation
  logic [LW-1:0] h_n, t_n, c_n;
  logic [CW-1:0] k_n;
  logic          ok_n;
  logic [31:0]   res_n;
  always_comb begin
    h_n = head;
    t_n = tail;
    c_n = cur;
    k_n = cnt;
    ok_n = 1'b0;
    res_n = '0;
    if (do_ins) begin
      ok_n = 1'b1;
      if (p == NIL) h_n = node;
      if (q == NIL) t_n = node;
      k_n = cnt + 1'b1;
      if (cur == NIL) c_n = node;
    end else if (rem) begin
      ok_n = 1'b1;
      res_n[SW-1:0] = tv;
      if (p == NIL) h_n = q;
      if (q == NIL) t_n = p;
      k_n = cnt - 1'b1;
      if (op == dllc_pkg::OP_DEL_CUR) begin
        c_n = (cur == tail) ? p : q;
      end else if (cur == tgt) begin
        c_n = NIL;
      end
    end else if (!empty) begin
      case (op)
        dllc_pkg::OP_PEEK_HEAD, dllc_pkg::OP_PEEK_TAIL, dllc_pkg::OP_PEEK_CUR: begin
          ok_n = 1'b1;
          res_n[SW-1:0] = tv;
        end
        dllc_pkg::OP_CUR_HEAD: begin
          ok_n = 1'b1;
          c_n = head;
        end
        dllc_pkg::OP_CUR_TAIL: begin
          ok_n = 1'b1;
          c_n = tail;
        end
        dllc_pkg::OP_CUR_FWD: begin
          if (cur != tail) begin
            ok_n = 1'b1;
            c_n = tn;
          end
        end
        dllc_pkg::OP_CUR_BACK: begin
          if (cur != head) begin
            ok_n = 1'b1;
            c_n = tp;
          end
        end
        default: begin
          ok_n = (op == dllc_pkg::OP_STATUS);
        end
      endcase
    end else begin
      ok_n = (op == dllc_pkg::OP_STATUS);
    end
    // Clear an empty list, park a dangling cursor on the head
    if (k_n == '0) begin
      h_n = NIL;
      t_n = NIL;
      c_n = NIL;
    end else if (c_n == NIL) begin
      c_n = h_n;
    end
  end

  assign cmd.ready = (state == S_IDLE);

  // Sequencer and list pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= NIL;
      tail  <= NIL;
      cur   <= NIL;
      cnt   <= '0;
      fs_sp <= '0;
      hw    <= '0;
      ov    <= 1'b0;
    end else begin
      if (ov && res.ready && state != S_WB) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op    <= cmd.func;
            vin   <= cmd.value_in[SW-1:0];
            tgt   <= tgt_sel;
            state <= S_LD;
          end
        end
        S_LD: begin
          tn    <= next_rd;
          tp    <= prev_rd;
          tv    <= val_rd;
          full  <= (fs_sp == '0) && (hw == CAP_C);
          node  <= (fs_sp != '0) ? {1'b0, fs_rd} : LW'(hw);
          state <= S_WA;
        end
        S_WA: begin
          if (do_ins) begin
            if (fs_sp != '0) fs_sp <= fs_sp - 1'b1;
            else hw <= hw + 1'b1;
          end else if (rem) begin
            fs_sp <= fs_sp + 1'b1;
          end
          state <= S_WB;
        end
        S_WB: begin
          if (!ov || res.ready) begin
            head    <= h_n;
            tail    <= t_n;
            cur     <= c_n;
            cnt     <= k_n;
            ov      <= 1'b1;
            o_ok    <= ok_n;
            o_value <= res_n;
            o_cnt   <= k_n;
            o_empty <= (k_n == '0);
            o_first <= (k_n == '0) || (c_n == h_n);
            o_last  <= (k_n == '0) || (c_n == t_n);
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid     = ov;
  assign res.value_out = o_value;
  assign res.ok        = o_ok;
  assign res.count     = $bits(res.count)'(o_cnt);
  assign res.is_empty  = o_empty;
  assign res.at_first  = o_first;
  assign res.at_last   = o_last;

endmodule
`default_nettype wire

// ===== hdl/dllc_ram.sv =====
`default_nettype none
module dllc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/dllc_checker.sv =====
`default_nettype none
module dllc_checker #(
  parameter int CAPACITY = 64
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] count,
  input wire logic       is_empty,
  input wire logic       at_first,
  input wire logic       at_last
);

  // Empty mark agrees with the count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == '0)))
    else $error("is_empty disagrees with count");

  // Empty list reports cursor at both ends
  a_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> (at_first && at_last))
    else $error("empty list without both end marks");

  // Count never exceeds the pool
  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(count) <= CAPACITY))
    else $error("count above capacity");

  // One command at a time: no accept right after an accept
  a_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("back to back command accepted");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(count)))
    else $error("stalled result dropped or changed");

endmodule

bind doubly_linked_list_with_cursor dllc_checker #(.CAPACITY(CAPACITY)) u_dllc_checker (
  .clk(clk), .rst(rst),
  .in_valid(cmd.valid), .in_ready(cmd.ready),
  .out_valid(res.valid), .out_ready(res.ready),
  .count(7'(res.count)), .is_empty(res.is_empty),
  .at_first(res.at_first), .at_last(res.at_last)
);
`default_nettype wire
